/* hw/rtl/nce_pkg.sv */
//------------------------------------------------------------------------------
// nce_pkg
// Shared types and constants for the LFSR noise channel with envelope.
//------------------------------------------------------------------------------
`default_nettype none

package nce_pkg;

  // Period timer width; the reload saturates at the largest positive value.
  localparam int TIMER_BITS = 25;

  localparam int DIV_W      = 8;
  localparam int DIV_COUNT  = 8;
  localparam int DIV_SEL_W  = $clog2(DIV_COUNT);
  localparam int SHIFT_W    = 4;
  localparam int PERIOD_W   = DIV_W + (1 << SHIFT_W) - 1;
  localparam int LFSR_W     = 15;
  localparam int LEN_W      = 7;
  localparam int VOL_W      = 4;
  localparam int ENV_PER_W  = 3;
  localparam int ENV_CNT_W  = 8;
  localparam int DATA_W     = 8;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  localparam logic [LEN_W-1:0]  LEN_FULL = LEN_W'(64);
  localparam logic [VOL_W-1:0]  VOL_MAX  = VOL_W'(15);
  localparam logic [LFSR_W-1:0] LFSR_SEED = {LFSR_W{1'b1}};

  localparam logic [DIV_W-1:0] DIV_RESET [DIV_COUNT] = '{
    8'd8, 8'd16, 8'd32, 8'd48, 8'd64, 8'd80, 8'd96, 8'd112
  };

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_ADVANCE  = 2'd1,
    OP_LENGTH   = 2'd2,
    OP_ENVELOPE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_LENGTH   = 2'd0,
    REG_ENVELOPE = 2'd1,
    REG_CLOCK    = 2'd2,
    REG_CONTROL  = 2'd3
  } reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_STEP,
    ST_RESULT
  } state_t;

  typedef struct packed {
    op_t               op;
    reg_t              reg_index;
    logic [DATA_W-1:0] write_data;
    logic [DATA_W-1:0] cycle_count;
  } item_t;

  typedef struct packed {
    logic [VOL_W-1:0] level;
    logic             active;
  } result_t;

  typedef struct packed {
    logic [SHIFT_W-1:0]   shift_amount;
    logic [DIV_SEL_W-1:0] divisor_select;
  } clk_sel_t;

endpackage

`default_nettype wire

/* hw/rtl/nce_cfg.sv */
//------------------------------------------------------------------------------
// nce_cfg
// Divisor register file on the APB port and the registered timer reload.
//------------------------------------------------------------------------------
`default_nettype none

module nce_cfg
  import nce_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  input  wire clk_sel_t              sel,
  output logic      [TIMER_BITS-1:0] reload
);

  localparam logic [31:0] TIMER_CAP = 32'((64'd1 << (TIMER_BITS - 1)) - 64'd1);

  logic [DIV_W-1:0]     divisor [DIV_COUNT];
  logic [DIV_SEL_W-1:0] widx;
  logic                 wr_en;
  logic [PERIOD_W-1:0]  period;
  logic [31:0]          period_ext;
  logic [31:0]          period_sat;

  assign pready = 1'b1;
  assign widx   = paddr[DIV_SEL_W+1:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign prdata = CFG_DATA_W'(divisor[widx]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_COUNT; i++) begin
        divisor[i] <= DIV_RESET[i];
      end
    end else if (wr_en) begin
      divisor[widx] <= pwdata[DIV_W-1:0];
    end
  end

  // Period = divisor << shift, saturated to the timer range, never zero.
  assign period     = PERIOD_W'(divisor[sel.divisor_select]) << sel.shift_amount;
  assign period_ext = 32'(period);

  always_comb begin
    if (period_ext > TIMER_CAP) begin
      period_sat = TIMER_CAP;
    end else if (period_ext == 32'd0) begin
      period_sat = 32'd1;
    end else begin
      period_sat = period_ext;
    end
  end

  always_ff @(posedge clk) begin
    reload <= period_sat[TIMER_BITS-1:0];
  end

endmodule

`default_nettype wire

/* hw/rtl/nce_core.sv */
//------------------------------------------------------------------------------
// nce_core
// Channel state, item sequencer and the shared period-timer adder.
//------------------------------------------------------------------------------
`default_nettype none

module nce_core
  import nce_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire item_t                 in_item,
  output logic                       in_ready,
  input  wire logic [TIMER_BITS-1:0] reload,
  output clk_sel_t                   sel,
  output logic                       done,
  input  wire logic                  out_free,
  output result_t                    result
);

  state_t state;
  state_t state_next;

  item_t                        item;
  logic [LFSR_W-1:0]            shift_reg;
  logic signed [TIMER_BITS-1:0] period_timer;
  logic [LEN_W-1:0]             length_left;
  logic                         length_on;
  logic                         chan_enabled;
  logic                         converter_on;
  logic [SHIFT_W-1:0]           shift_amount;
  logic                         short_mode;
  logic [DIV_SEL_W-1:0]         divisor_select;
  logic [VOL_W-1:0]             volume_now;
  logic [VOL_W-1:0]             volume_start;
  logic                         env_up;
  logic [ENV_PER_W-1:0]         env_period;
  logic [ENV_CNT_W-1:0]         env_countdown;

  logic signed [TIMER_BITS-1:0] operand;
  logic signed [TIMER_BITS-1:0] sum;
  logic                         timer_expired;
  logic [ENV_CNT_W-1:0]         env_dec;
  logic                         restart_on;
  logic                         env_on;
  logic                         active;

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s,
                                                  input logic short_fb);
    logic              fb;
    logic [LFSR_W-1:0] n;
    fb = s[0] ^ s[1];
    n  = {fb, s[LFSR_W-1:1]};
    if (short_fb) begin
      n[6] = fb;
    end
    return n;
  endfunction

  assign sel.shift_amount   = shift_amount;
  assign sel.divisor_select = divisor_select;

  // One adder: subtract the cycle count on entry, add the reload on each step.
  assign operand       = (state == ST_EXEC) ? -$signed(TIMER_BITS'(item.cycle_count))
                                            : $signed(reload);
  assign sum           = period_timer + operand;
  assign timer_expired = period_timer[TIMER_BITS-1] || (period_timer == '0);

  assign env_dec    = env_countdown - ENV_CNT_W'(1);
  assign restart_on = (volume_start != '0) || env_up;
  assign env_on     = |item.write_data[7:3];

  assign in_ready = (state == ST_IDLE);
  assign done     = (state == ST_RESULT);
  assign active   = chan_enabled && converter_on;
  assign result.active = active;
  assign result.level  = (active && !shift_reg[0]) ? volume_now : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = (item.op == OP_ADVANCE) ? ST_STEP : ST_RESULT;
      end
      ST_STEP: begin
        if (!timer_expired) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_reg      <= LFSR_SEED;
      period_timer   <= '0;
      length_left    <= '0;
      length_on      <= 1'b0;
      chan_enabled   <= 1'b0;
      converter_on   <= 1'b0;
      shift_amount   <= '0;
      short_mode     <= 1'b0;
      divisor_select <= '0;
      volume_now     <= '0;
      volume_start   <= '0;
      env_up         <= 1'b0;
      env_period     <= '0;
      env_countdown  <= '0;
    end else begin
      unique case (state)
        ST_EXEC: begin
          unique case (item.op)
            OP_WRITE: begin
              unique case (item.reg_index)
                REG_LENGTH: begin
                  length_left <= LEN_FULL - {1'b0, item.write_data[5:0]};
                end
                REG_ENVELOPE: begin
                  converter_on <= env_on;
                  if (!env_on) begin
                    chan_enabled <= 1'b0;
                  end
                  volume_start <= item.write_data[7:4];
                  env_up       <= item.write_data[3];
                  env_period   <= item.write_data[2:0];
                end
                REG_CLOCK: begin
                  shift_amount   <= item.write_data[7:4];
                  short_mode     <= item.write_data[3];
                  divisor_select <= item.write_data[2:0];
                end
                REG_CONTROL: begin
                  length_on <= item.write_data[6];
                  if (item.write_data[7]) begin
                    if (length_left == '0) begin
                      length_left <= LEN_FULL;
                    end
                    period_timer  <= $signed(reload);
                    shift_reg     <= LFSR_SEED;
                    volume_now    <= volume_start;
                    env_countdown <= ENV_CNT_W'(env_period);
                    converter_on  <= restart_on;
                    chan_enabled  <= restart_on;
                  end
                end
                default: ;
              endcase
            end
            OP_ADVANCE: begin
              period_timer <= sum;
            end
            OP_LENGTH: begin
              if (length_on && length_left != '0) begin
                length_left <= length_left - LEN_W'(1);
                if (length_left == LEN_W'(1)) begin
                  chan_enabled <= 1'b0;
                end
              end
            end
            OP_ENVELOPE: begin
              if (env_period != '0) begin
                if (env_dec == '0) begin
                  env_countdown <= ENV_CNT_W'(env_period);
                  if (env_up) begin
                    if (volume_now != VOL_MAX) begin
                      volume_now <= volume_now + VOL_W'(1);
                    end
                  end else if (volume_now != '0) begin
                    volume_now <= volume_now - VOL_W'(1);
                  end
                end else begin
                  env_countdown <= env_dec;
                end
              end
            end
            default: ;
          endcase
        end
        ST_STEP: begin
          // Reload and clock the LFSR once per expired period.
          if (timer_expired) begin
            period_timer <= sum;
            shift_reg    <= lfsr_step(shift_reg, short_mode);
          end
        end
        default: ;
      endcase
    end
  end

  a_timer_idle_nonneg: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !period_timer[TIMER_BITS-1])
    else $error("period timer negative while idle");

  a_length_range: assert property (@(posedge clk) disable iff (rst)
    length_left <= LEN_FULL)
    else $error("length counter above full length");

  a_enable_needs_converter: assert property (@(posedge clk) disable iff (rst)
    chan_enabled |-> converter_on)
    else $error("channel enabled with converter off");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT && !out_free) |=> (state == ST_RESULT))
    else $error("result dropped while output register busy");

endmodule

`default_nettype wire

/* hw/rtl/noise_channel_lfsr_envelope_top.sv */
//------------------------------------------------------------------------------
// noise_channel_lfsr_envelope_top
// Noise sound channel: 15-bit LFSR, period timer, length counter, envelope.
//------------------------------------------------------------------------------
// Usage:
//   Slave stream carries one command word per handshake: tuser selects the
//   operation (register write, advance, length tick, envelope tick) and the
//   register, tdata carries the written byte and the cycle count.
//   Master stream returns one word per command: the output level and the
//   active flag as they stand after the command.
//   The APB port holds the eight divisor registers (byte address 4*i);
//   write them only while the channel is idle.
// Timing:
//   A register write or tick is accepted in idle, executed, then held in the
//   result state until the output register is free. An advance also runs
//   the step state, clocking the LFSR once per expired period (up to 32
//   times with the default shortest period of 8, up to 256 with period 1);
//   the single timer adder handles one reload per cycle. The reload value is
//   registered, so it follows a clock register or divisor write in the cycle after.
// Reset: rst clears all channel state, seeds the LFSR with all ones and
//   restores the default divisors. No clearing pass is needed.
// Stall: the result waits in the output register; the next command is
//   accepted meanwhile, and its result holds until the register frees.
//------------------------------------------------------------------------------
`default_nettype none

module noise_channel_lfsr_envelope_top
  import nce_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // slave stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [15:0]           s_tdata,  // write_data[7:0], cycle_count[15:8]
  input  wire logic [3:0]            s_tuser,  // op[1:0], reg_index[3:2]
  // master stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [7:0]            m_tdata,  // level[3:0], active[4], zero[7:5]
  // APB configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  item_t                  in_item;
  clk_sel_t               sel;
  logic [TIMER_BITS-1:0]  reload;
  logic                   done;
  logic                   out_free;
  result_t                result;

  // Unpack the command word.
  assign in_item.op          = op_t'(s_tuser[1:0]);
  assign in_item.reg_index   = reg_t'(s_tuser[3:2]);
  assign in_item.write_data  = s_tdata[7:0];
  assign in_item.cycle_count = s_tdata[15:8];

  // Output register is free when empty or being drained this cycle.
  assign out_free = !m_tvalid || m_tready;

  nce_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sel     (sel),
    .reload  (reload)
  );

  nce_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_item  (in_item),
    .in_ready (s_tready),
    .reload   (reload),
    .sel      (sel),
    .done     (done),
    .out_free (out_free),
    .result   (result)
  );

  // Hold the result word until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && out_free) begin
      m_tdata <= {3'b000, result.active, result.level};
    end
  end

endmodule

`default_nettype wire

/* tb/tb_noise_channel_lfsr_envelope_top.sv */
//------------------------------------------------------------------------------
// tb_noise_channel_lfsr_envelope_top
// Self-checking bench for the LFSR noise channel with length and envelope.
// Command words go in on the slave stream. A transaction-level model of the channel
// in this file predicts the level and active flag of every returned word, and
// a monitor compares each one in order. The divisor table is reprogrammed over
// APB between phases, while the channel is drained. Both stream sides idle at
// random, and one phase holds the output off long enough to back up the input.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_noise_channel_lfsr_envelope_top;
  import nce_pkg::*;

  // Generous bound: even if every word were the longest advance under random
  // stalls, a correct run would need well under a fifth of this.
  localparam int CYCLE_LIMIT = 3_000_000;
  // An advance with a period of 1 is the longest command; wait out one at the end.
  localparam int DRAIN_CYCLES = 300;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata = '0;   // write_data[7:0], cycle_count[15:8]
  logic [3:0]            s_tuser = '0;   // op[1:0], reg_index[3:2]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;        // level[3:0], active[4], zero[7:5]
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  noise_channel_lfsr_envelope_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 4 ns clock: 2 ns high, 2 ns low.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Channel model: divisor table plus all channel state; all but the timer at the block's widths
  // ---------------------------------------------------------------------------
  logic [DIV_W-1:0]     div_tab [DIV_COUNT];
  logic [LFSR_W-1:0]    ch_lfsr;
  longint               ch_timer;       // signed period timer
  logic [LEN_W-1:0]     ch_len_left;
  bit                   ch_len_en;
  bit                   ch_chan_on;
  bit                   ch_dac_on;
  logic [SHIFT_W-1:0]   ch_shamt;
  bit                   ch_narrow;      // short mode: feedback also into bit 6
  logic [DIV_SEL_W-1:0] ch_div_sel;
  logic [VOL_W-1:0]     ch_vol;
  logic [VOL_W-1:0]     ch_vol_init;
  bit                   ch_env_inc;
  logic [ENV_PER_W-1:0] ch_env_per;
  logic [ENV_CNT_W-1:0] ch_env_cnt;

  // Levels still owed by the block, oldest first.
  result_t level_queue [$];

  int  words_sent;
  int  words_checked;
  int  mismatches;
  int  cyc_cnt;
  bit  src_idle_en = 1'b1;
  bit  snk_idle_en = 1'b1;
  int  hold_req;     // set by a test: length of a receiver hold-off in cycles

  // Timer reload: divisor shifted, saturated to the timer's positive range, never 0.
  function automatic longint period_reload();
    longint p;
    longint cap;
    p   = longint'(div_tab[ch_div_sel]) << ch_shamt;
    cap = (longint'(1) << (TIMER_BITS - 1)) - 1;
    if (p > cap) p = cap;
    if (p == 0) p = 1;
    return p;
  endfunction

  // Apply one command word to the model and return the level it produces.
  function automatic result_t channel_step(op_t op, reg_t r, logic [7:0] wd, logic [7:0] cc);
    result_t res;
    logic    fb;
    bit      on;
    case (op)
      OP_WRITE: begin
        case (r)
          REG_LENGTH: ch_len_left = LEN_W'(64 - wd[5:0]);
          REG_ENVELOPE: begin
            ch_dac_on = |wd[7:3];
            if (!ch_dac_on) ch_chan_on = 1'b0;
            ch_vol_init = wd[7:4];
            ch_env_inc  = wd[3];
            ch_env_per  = wd[2:0];
          end
          REG_CLOCK: begin
            ch_shamt   = wd[7:4];
            ch_narrow  = wd[3];
            ch_div_sel = wd[2:0];
          end
          default: begin
            ch_len_en = wd[6];
            if (wd[7]) begin
              // restart: reload everything from the programmed registers
              if (ch_len_left == 0) ch_len_left = LEN_FULL;
              ch_timer   = period_reload();
              ch_lfsr    = LFSR_SEED;
              ch_vol     = ch_vol_init;
              ch_env_cnt = ENV_CNT_W'(ch_env_per);
              ch_dac_on  = (ch_vol_init != 0) || ch_env_inc;
              ch_chan_on = ch_dac_on;
            end
          end
        endcase
      end
      OP_ADVANCE: begin
        ch_timer -= longint'(cc);
        while (ch_timer <= 0) begin
          ch_timer += period_reload();
          fb = ch_lfsr[0] ^ ch_lfsr[1];
          ch_lfsr = {fb, ch_lfsr[LFSR_W-1:1]};
          if (ch_narrow) ch_lfsr[6] = fb;
        end
      end
      OP_LENGTH: begin
        if (ch_len_en && ch_len_left != 0) begin
          ch_len_left--;
          if (ch_len_left == 0) ch_chan_on = 1'b0;
        end
      end
      default: begin
        if (ch_env_per != 0) begin
          ch_env_cnt = ch_env_cnt - 1'b1;   // wraps 0 -> 255
          if (ch_env_cnt == 0) begin
            ch_env_cnt = ENV_CNT_W'(ch_env_per);
            if (ch_env_inc) begin
              if (ch_vol != VOL_MAX) ch_vol++;
            end else if (ch_vol != 0) begin
              ch_vol--;
            end
          end
        end
      end
    endcase
    on = ch_chan_on && ch_dac_on;
    res.active = on;
    res.level  = (on && !ch_lfsr[0]) ? ch_vol : '0;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Cycle watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles, %0d levels still owed",
               $time, CYCLE_LIMIT, level_queue.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  int hold_left;
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (snk_idle_en && $urandom_range(0, 99) < 19) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare every returned word against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : level_check
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (level_queue.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word: expected none, actual level %0d active %0d",
                 $time, m_tdata[3:0], m_tdata[4]);
      end else begin
        want = level_queue.pop_front();
        words_checked++;
        if (m_tdata[3:0] !== want.level) begin
          mismatches++;
          $display("%0t: level mismatch: expected %0d, actual %0d",
                   $time, want.level, m_tdata[3:0]);
        end
        if (m_tdata[4] !== want.active) begin
          mismatches++;
          $display("%0t: active mismatch: expected %0d, actual %0d",
                   $time, want.active, m_tdata[4]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stream and APB drivers
  // ---------------------------------------------------------------------------

  // Offer one command word, hold it until accepted, then record the prediction.
  // Valid stays high on return so the next word can follow back to back.
  task automatic send_word(op_t op, reg_t r, logic [7:0] wd, logic [7:0] cc);
    if (src_idle_en && $urandom_range(0, 99) < 19) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 19);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {cc, wd};
    s_tuser  <= {r, op};
    do @(posedge clk); while (!s_tready);
    level_queue.push_back(channel_step(op, r, wd, cc));
    words_sent++;
  endtask

  // Drop valid and wait until every owed word has come back.
  task automatic drain_channel();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (level_queue.size() != 0);
  endtask

  // Two-phase APB write of one divisor; only called with the channel drained.
  task automatic write_divisor(int idx, logic [DIV_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(4 * idx);
    pwdata  <= CFG_DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    div_tab[idx] = val;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Fully random word: any op, any register, random unused fields.
  task automatic send_noise_word();
    send_word(op_t'($urandom_range(0, 3)), reg_t'($urandom_range(0, 3)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // Well-formed note: program envelope and clock, maybe length, write control (mostly
  // a trigger), then run a string of advances and ticks with a stray register write now and then.
  task automatic send_note(output int n);
    int k;
    int pick;
    n = 0;
    send_word(OP_WRITE, REG_ENVELOPE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    send_word(OP_WRITE, REG_CLOCK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    n += 2;
    if ($urandom_range(0, 1)) begin
      send_word(OP_WRITE, REG_LENGTH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      n++;
    end
    send_word(OP_WRITE, REG_CONTROL,
              {($urandom_range(0, 9) != 0), 7'($urandom_range(0, 127))},
              8'($urandom_range(0, 255)));
    n++;
    k = $urandom_range(4, 14);
    repeat (k) begin
      pick = $urandom_range(0, 99);
      if (pick < 48)
        send_word(OP_ADVANCE, reg_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      else if (pick < 70)
        send_word(OP_LENGTH, reg_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      else if (pick < 92)
        send_word(OP_ENVELOPE, reg_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      else
        send_word(OP_WRITE, reg_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      n++;
    end
  endtask

  // Mostly notes; about one pick in seven is a single pure noise word instead.
  task automatic send_random_words(int target);
    int done;
    int n;
    done = 0;
    while (done < target) begin
      if ($urandom_range(0, 99) < 15) begin
        send_noise_word();
        done++;
      end else begin
        send_note(n);
        done += n;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes of every register field, each op, and the corner cases of the
  // timer, length counter and envelope.
  task automatic test_directed_cases();
    send_word(OP_ADVANCE,  REG_LENGTH,   8'h00, 8'h00);  // timer at zero: reload and shift
    send_word(OP_LENGTH,   REG_LENGTH,   8'h00, 8'h00);  // length disabled: no effect
    send_word(OP_ENVELOPE, REG_LENGTH,   8'h00, 8'h00);  // envelope period zero: no effect
    send_word(OP_WRITE,    REG_LENGTH,   8'hFF, 8'h00);  // one tick left
    send_word(OP_WRITE,    REG_ENVELOPE, 8'hF9, 8'h00);  // full volume, up, period 1
    send_word(OP_WRITE,    REG_CLOCK,    8'h00, 8'h00);  // shortest shift, long mode
    send_word(OP_WRITE,    REG_CONTROL,  8'hC0, 8'h00);  // trigger with length enabled
    send_word(OP_ADVANCE,  REG_LENGTH,   8'h00, 8'hFF);
    send_word(OP_ENVELOPE, REG_LENGTH,   8'h00, 8'h00);  // volume pinned at the top
    send_word(OP_WRITE,    REG_CLOCK,    8'hFF, 8'h00);  // largest shift, short mode, code 7
    send_word(OP_ADVANCE,  REG_LENGTH,   8'h00, 8'hFF);
    send_word(OP_LENGTH,   REG_LENGTH,   8'h00, 8'h00);  // length expires, channel off
    send_word(OP_LENGTH,   REG_LENGTH,   8'h00, 8'h00);  // already expired
    send_word(OP_WRITE,    REG_ENVELOPE, 8'h11, 8'h00);  // volume 1, down, period 1
    send_word(OP_WRITE,    REG_CONTROL,  8'h80, 8'h00);  // trigger refills the length
    send_word(OP_ENVELOPE, REG_LENGTH,   8'h00, 8'h00);  // down to 0
    send_word(OP_ENVELOPE, REG_LENGTH,   8'h00, 8'h00);  // volume pinned at the bottom
    send_word(OP_WRITE,    REG_ENVELOPE, 8'h00, 8'h00);  // converter off
    send_word(OP_WRITE,    REG_CONTROL,  8'h80, 8'h00);  // trigger with nothing to play
    send_word(OP_WRITE,    REG_ENVELOPE, 8'h08, 8'h00);  // volume 0 rising, period 0
    send_word(OP_WRITE,    REG_CONTROL,  8'h80, 8'h00);  // countdown loads 0
    send_word(OP_WRITE,    REG_ENVELOPE, 8'h09, 8'h00);  // period 1 without a trigger
    send_word(OP_ENVELOPE, REG_LENGTH,   8'h00, 8'h00);  // countdown wraps to 255
    send_word(OP_WRITE,    REG_LENGTH,   8'h00, 8'h00);  // full length
    send_word(OP_WRITE,    REG_CLOCK,    8'h08, 8'h00);  // short mode, shift 0
    send_word(OP_ADVANCE,  REG_CONTROL,  8'hFF, 8'h25);
    drain_channel();
  endtask

  // Reprogram all eight divisors, then run random notes under that table.
  task automatic test_divisor_setting(int mode, int n_words);
    int zero_idx;
    logic [DIV_W-1:0] v;
    zero_idx = $urandom_range(0, DIV_COUNT - 1);
    for (int i = 0; i < DIV_COUNT; i++) begin
      case (mode)
        0: v = DIV_RESET[i];
        1: v = 8'd255;
        2: v = 8'd1;
        3: v = 8'($urandom_range(1, 255));
        default: v = (i == zero_idx) ? 8'd0 : 8'($urandom_range(1, 255));  // zero divisor
      endcase
      write_divisor(i, v);
    end
    send_random_words(n_words);
    drain_channel();
  endtask

  // No idling on either side: words back to back through the whole pipeline.
  task automatic test_back_to_back();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    send_random_words(150);
    drain_channel();
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
  endtask

  // Hold the output off while words keep coming, so the input has to stall.
  task automatic test_output_backpressure();
    hold_req = 400;
    repeat (12) begin
      send_word(OP_ENVELOPE, reg_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
      send_word(OP_LENGTH, reg_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
      send_word(OP_ADVANCE, reg_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 40)));
    end
    drain_channel();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    // model state after reset
    for (int i = 0; i < DIV_COUNT; i++) div_tab[i] = DIV_RESET[i];
    ch_lfsr     = LFSR_SEED;
    ch_timer    = 0;
    ch_len_left = '0;
    ch_len_en   = 1'b0;
    ch_chan_on  = 1'b0;
    ch_dac_on   = 1'b0;
    ch_shamt    = '0;
    ch_narrow   = 1'b0;
    ch_div_sel  = '0;
    ch_vol      = '0;
    ch_vol_init = '0;
    ch_env_inc  = 1'b0;
    ch_env_per  = '0;
    ch_env_cnt  = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_divisor_setting(0, 220);   // default table, untouched by APB until now
    test_divisor_setting(1, 200);   // longest base periods
    test_divisor_setting(2, 200);   // shortest base periods
    test_divisor_setting(3, 220);
    test_back_to_back();
    test_output_backpressure();
    test_divisor_setting(4, 200);   // one divisor zeroed
    test_divisor_setting(0, 100);   // defaults restored

    s_tvalid <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d command words (directed corners, five divisor tables,", words_sent);
    $display("back-to-back and output hold-off); %0d levels compared.", words_checked);
    if (mismatches == 0 && level_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d levels never returned", mismatches, level_queue.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/nce_pkg.sv
hw/rtl/nce_cfg.sv
hw/rtl/nce_core.sv
hw/rtl/noise_channel_lfsr_envelope_top.sv
tb/tb_noise_channel_lfsr_envelope_top.sv
